// ===== hdl/prescaled_multi_timer_watchdog_defines.svh =====
// Assertion macros for the prescaled multi-timer watchdog block.
// Used by the top level; no other dependencies.
`ifndef PRESCALED_MULTI_TIMER_WATCHDOG_DEFINES_SVH
`define PRESCALED_MULTI_TIMER_WATCHDOG_DEFINES_SVH

`ifndef NO_ASSERTIONS
// Checked at every clock edge outside reset
`define PMTW_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);
// Checked at every clock edge, reset included
`define PMTW_ASSERT_ALWAYS(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define PMTW_ASSERT(lbl, prop, msg)
`define PMTW_ASSERT_ALWAYS(lbl, prop, msg)
`endif

`endif

// ===== hdl/pmtw_pkg.sv =====
// Package for the prescaled multi-timer watchdog: command codes, register
// map constants, control bit layout and shared structs. No dependencies.
`default_nettype none

package pmtw_pkg;

	localparam int unsigned DATA_W = 32;
	localparam int unsigned ADDR_W = 5;
	localparam int unsigned IRQ_W  = 7;

	// Item command codes
	typedef enum logic [1:0] {
		CMD_TICK  = 2'd0,
		CMD_READ  = 2'd1,
		CMD_WRITE = 2'd2
	} cmd_e;

	// Register group 0 holds the global registers, group n timer n
	localparam logic [2:0] GRP_GLOBAL = 3'd0;

	// Offsets within the global group
	localparam logic [1:0] REG_SCALER        = 2'd0;
	localparam logic [1:0] REG_SCALER_RELOAD = 2'd1;
	localparam logic [1:0] REG_CONFIG        = 2'd2;

	// Offsets within a timer group (latch reads as zero)
	localparam logic [1:0] REG_COUNT  = 2'd0;
	localparam logic [1:0] REG_RELOAD = 2'd1;
	localparam logic [1:0] REG_CTRL   = 2'd2;

	localparam logic [DATA_W-1:0] CONFIG_MASK = 32'h7;

	// Bus layout of a timer control register
	localparam int unsigned CTRL_EN_BIT    = 0;
	localparam int unsigned CTRL_PER_BIT   = 1;
	localparam int unsigned CTRL_LOAD_BIT  = 2;
	localparam int unsigned CTRL_IE_BIT    = 3;
	localparam int unsigned CTRL_PEND_BIT  = 4;
	localparam int unsigned CTRL_CHAIN_BIT = 5;

	// Stored control bits of one timer
	typedef struct packed {
		logic en;
		logic per;
		logic ie;
		logic pend;
		logic chain;
	} timer_stat_t;

	// Per-item strobes to one timer
	typedef struct packed {
		logic tick;
		logic wr_count;
		logic wr_reload;
		logic wr_ctrl;
	} timer_cmd_t;

	// Per-item strobes to the prescaler
	typedef struct packed {
		logic tick;
		logic wr_count;
		logic wr_reload;
	} scaler_cmd_t;

	// Control bits as seen on the bus; load always reads as zero
	function automatic logic [DATA_W-1:0] stat_to_bus(timer_stat_t s);
		logic [DATA_W-1:0] r;
		r = '0;
		r[CTRL_EN_BIT]    = s.en;
		r[CTRL_PER_BIT]   = s.per;
		r[CTRL_IE_BIT]    = s.ie;
		r[CTRL_PEND_BIT]  = s.pend;
		r[CTRL_CHAIN_BIT] = s.chain;
		return r;
	endfunction

endpackage

`default_nettype wire

// ===== hdl/pmtw_ifs.sv =====
// Handshake channel interfaces of the prescaled multi-timer watchdog:
// the request channel (items in) and the response channel (results out).
// Depends on pmtw_pkg.
`default_nettype none

interface pmtw_req_if;
	import pmtw_pkg::*;

	logic              valid;
	logic              ready;
	cmd_e              command;
	logic [ADDR_W-1:0] address;
	logic [DATA_W-1:0] write_data;

	modport source (output valid, command, address, write_data, input ready);
	modport sink (input valid, command, address, write_data, output ready);
endinterface

interface pmtw_rsp_if;
	import pmtw_pkg::*;

	logic              valid;
	logic              ready;
	logic [DATA_W-1:0] read_data;
	logic [IRQ_W-1:0]  irq_lines;
	logic              watchdog_fired;

	modport source (output valid, read_data, irq_lines, watchdog_fired, input ready);
	modport sink (input valid, read_data, irq_lines, watchdog_fired, output ready);
endinterface

`default_nettype wire

// ===== hdl/prescaled_multi_timer_watchdog.sv =====
// Top level of the prescaled multi-timer watchdog: input register, register
// decode, prescaler, timer slots and result register.
// Depends on pmtw_pkg, pmtw_ifs, pmtw_prescaler, pmtw_timer and the defines header.
`default_nettype none

// Timer unit with a shared prescaler, NUM_TIMERS down counters (all but the
// first chain-capable) and a watchdog output, driven by items on the req channel
// (one clock tick, register read or register write each) and answering each with
// one result on the rsp channel. Throughput is one item per clock while the rsp
// side does not stall: an accepted item waits in the input register until the
// result slot is free, where the prescaler, the timer underflow chain and the read
// mux then act on it in a single pass, and its result is registered in the output
// register. The rsp stage holds a waiting result while the next item is already
// taken into the input register. irq_lines and watchdog_fired reflect the state
// left by the item whose result is shown.
module prescaled_multi_timer_watchdog #(
	parameter int unsigned NUM_TIMERS    = 3,
	parameter int unsigned SCALER_WIDTH  = 16,
	parameter int unsigned COUNTER_WIDTH = 32
) (
	input wire logic  clk,
	input wire logic  arst_n,
	pmtw_req_if.sink  req,
	pmtw_rsp_if.source rsp
);
	import pmtw_pkg::*;

	`include "prescaled_multi_timer_watchdog_defines.svh"

	// Input register
	logic              valid_s1;
	cmd_e              cmd_s1;
	logic [ADDR_W-1:0] addr_s1;
	logic [DATA_W-1:0] wdata_s1;

	// Result register
	logic              out_valid_q;
	logic [DATA_W-1:0] rd_q;
	logic [DATA_W-1:0] rd_d;

	logic        advance;
	logic        do_tick;
	logic        do_wr;
	logic [2:0]  grp;
	logic [1:0]  off;

	scaler_cmd_t             sc_cmd;
	logic                    pre_tick;
	logic [SCALER_WIDTH-1:0] sc_count;
	logic [SCALER_WIDTH-1:0] sc_reload;

	timer_cmd_t               t_cmd    [NUM_TIMERS];
	logic                     t_under  [NUM_TIMERS];
	logic [COUNTER_WIDTH-1:0] t_count  [NUM_TIMERS];
	logic [COUNTER_WIDTH-1:0] t_reload [NUM_TIMERS];
	timer_stat_t              t_stat   [NUM_TIMERS];

	logic [IRQ_W-1:0] irq_all;

	// Handshake: the input register moves on when the result slot is free
	assign advance   = valid_s1 && (!out_valid_q || rsp.ready);
	assign req.ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (req.ready) begin
			valid_s1 <= req.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (req.ready && req.valid) begin
			cmd_s1   <= req.command;
			addr_s1  <= req.address;
			wdata_s1 <= req.write_data;
		end
	end

	// Decode
	assign grp     = addr_s1[ADDR_W-1:2];
	assign off     = addr_s1[1:0];
	assign do_tick = advance && (cmd_s1 == CMD_TICK);
	assign do_wr   = advance && (cmd_s1 == CMD_WRITE);

	assign sc_cmd.tick      = do_tick;
	assign sc_cmd.wr_count  = do_wr && (grp == GRP_GLOBAL) && (off == REG_SCALER);
	assign sc_cmd.wr_reload = do_wr && (grp == GRP_GLOBAL) && (off == REG_SCALER_RELOAD);

	pmtw_prescaler #(
		.SCALER_WIDTH(SCALER_WIDTH)
	) u_prescaler (
		.clk     (clk),
		.arst_n  (arst_n),
		.cmd     (sc_cmd),
		.wdata   (wdata_s1),
		.pre_tick(pre_tick),
		.count   (sc_count),
		.reload  (sc_reload)
	);

	// Timer slots, underflow rippling from each slot to the next
	for (genvar i = 0; i < NUM_TIMERS; i++) begin : g_timer
		logic sel;
		logic prev_under;

		assign sel = (grp == 3'(i + 1));
		assign t_cmd[i].tick      = do_tick;
		assign t_cmd[i].wr_count  = do_wr && sel && (off == REG_COUNT);
		assign t_cmd[i].wr_reload = do_wr && sel && (off == REG_RELOAD);
		assign t_cmd[i].wr_ctrl   = do_wr && sel && (off == REG_CTRL);

		if (i == 0) begin : g_first
			assign prev_under = 1'b0;
		end else begin : g_next
			assign prev_under = t_under[i-1];
		end

		pmtw_timer #(
			.COUNTER_WIDTH(COUNTER_WIDTH),
			.IS_FIRST     (i == 0)
		) u_timer (
			.clk       (clk),
			.arst_n    (arst_n),
			.cmd       (t_cmd[i]),
			.wdata     (wdata_s1),
			.pre_tick  (pre_tick),
			.prev_under(prev_under),
			.under     (t_under[i]),
			.count     (t_count[i]),
			.reload    (t_reload[i]),
			.stat      (t_stat[i])
		);
	end

	// Read mux; unmapped registers and non-read items give zero
	always_comb begin
		rd_d = '0;
		if (cmd_s1 == CMD_READ) begin
			if (grp == GRP_GLOBAL) begin
				case (off)
					REG_SCALER:        rd_d = DATA_W'(sc_count);
					REG_SCALER_RELOAD: rd_d = DATA_W'(sc_reload);
					REG_CONFIG:        rd_d = DATA_W'(NUM_TIMERS) & CONFIG_MASK;
					default:           rd_d = '0;
				endcase
			end
			for (int i = 0; i < NUM_TIMERS; i++) begin
				if (grp == 3'(i + 1)) begin
					case (off)
						REG_COUNT:  rd_d = DATA_W'(t_count[i]);
						REG_RELOAD: rd_d = DATA_W'(t_reload[i]);
						REG_CTRL:   rd_d = stat_to_bus(t_stat[i]);
						default:    rd_d = '0;
					endcase
				end
			end
		end
	end

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			rd_q <= rd_d;
		end
	end

	// Interrupt lines from the stored state
	always_comb begin
		irq_all = '0;
		for (int i = 0; i < NUM_TIMERS; i++) begin
			irq_all[i] = t_stat[i].pend && t_stat[i].ie;
		end
	end

	assign rsp.valid          = out_valid_q;
	assign rsp.read_data      = rd_q;
	assign rsp.irq_lines      = irq_all;
	assign rsp.watchdog_fired = t_stat[NUM_TIMERS-1].pend;

	// Assertions
	`PMTW_ASSERT(a_adv_gives_result, advance |=> out_valid_q, "item advanced without a result")
	`PMTW_ASSERT(a_nonread_zero, (advance && cmd_s1 != CMD_READ) |=> (rd_q == '0), "non-read item returned data")
	`PMTW_ASSERT(a_stall_holds_state, (out_valid_q && !rsp.ready) |=> $stable(sc_count), "state moved while result stalled")
	`PMTW_ASSERT(a_scaler_dec, (do_tick && sc_count != '0) |=> (sc_count == $past(sc_count) - SCALER_WIDTH'(1)), "prescaler did not count down")

endmodule

`default_nettype wire

// ===== hdl/pmtw_prescaler.sv =====
// Shared prescaler: down counter with reload that ticks the timers on
// underflow. Depends on pmtw_pkg.
`default_nettype none

module pmtw_prescaler #(
	parameter int unsigned SCALER_WIDTH = 16
) (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire pmtw_pkg::scaler_cmd_t      cmd,
	input  wire logic [pmtw_pkg::DATA_W-1:0] wdata,
	output logic                            pre_tick,
	output logic [SCALER_WIDTH-1:0]         count,
	output logic [SCALER_WIDTH-1:0]         reload
);
	import pmtw_pkg::*;

	logic [SCALER_WIDTH-1:0] count_q;
	logic [SCALER_WIDTH-1:0] reload_q;

	// underflow when a tick finds the count at zero
	assign pre_tick = cmd.tick && (count_q == '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q  <= '1;
			reload_q <= '1;
		end else begin
			if (cmd.tick) begin
				count_q <= pre_tick ? reload_q : count_q - SCALER_WIDTH'(1);
			end else if (cmd.wr_count) begin
				count_q <= wdata[SCALER_WIDTH-1:0];
			end
			if (cmd.wr_reload) begin
				reload_q <= wdata[SCALER_WIDTH-1:0];
			end
		end
	end

	assign count  = count_q;
	assign reload = reload_q;

endmodule

`default_nettype wire

// ===== hdl/pmtw_timer.sv =====
// One down-counting timer slot: counter, reload value and control bits,
// with chaining on the previous slot's underflow. Depends on pmtw_pkg.
`default_nettype none

module pmtw_timer #(
	parameter int unsigned COUNTER_WIDTH = 32,
	parameter bit          IS_FIRST      = 1'b0
) (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire pmtw_pkg::timer_cmd_t        cmd,
	input  wire logic [pmtw_pkg::DATA_W-1:0] wdata,
	input  wire logic                        pre_tick,
	input  wire logic                        prev_under,
	output logic                             under,
	output logic [COUNTER_WIDTH-1:0]         count,
	output logic [COUNTER_WIDTH-1:0]         reload,
	output pmtw_pkg::timer_stat_t            stat
);
	import pmtw_pkg::*;

	logic [COUNTER_WIDTH-1:0] count_q;
	logic [COUNTER_WIDTH-1:0] reload_q;
	timer_stat_t              stat_q;
	logic                     go;
	logic                     active;

	// chained slots count on the previous slot's underflow
	assign go     = (!IS_FIRST && stat_q.chain) ? prev_under : pre_tick;
	assign active = cmd.tick && stat_q.en && go;
	assign under  = active && (count_q == '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q  <= '0;
			reload_q <= '0;
			stat_q   <= '0;
		end else begin
			if (active) begin
				if (under) begin
					// periodic reloads, one-shot wraps and disables
					if (stat_q.per) begin
						count_q <= reload_q;
					end else begin
						count_q   <= '1;
						stat_q.en <= 1'b0;
					end
					if (stat_q.ie) begin
						stat_q.pend <= 1'b1;
					end
				end else begin
					count_q <= count_q - COUNTER_WIDTH'(1);
				end
			end
			if (cmd.wr_count) begin
				count_q <= wdata[COUNTER_WIDTH-1:0];
			end
			if (cmd.wr_reload) begin
				reload_q <= wdata[COUNTER_WIDTH-1:0];
			end
			// control write: pending is write-one-to-clear, load copies reload
			if (cmd.wr_ctrl) begin
				stat_q.en    <= wdata[CTRL_EN_BIT];
				stat_q.per   <= wdata[CTRL_PER_BIT];
				stat_q.ie    <= wdata[CTRL_IE_BIT];
				stat_q.chain <= wdata[CTRL_CHAIN_BIT];
				stat_q.pend  <= stat_q.pend && !wdata[CTRL_PEND_BIT];
				if (wdata[CTRL_LOAD_BIT]) begin
					count_q <= reload_q;
				end
			end
		end
	end

	assign count  = count_q;
	assign reload = reload_q;
	assign stat   = stat_q;

endmodule

`default_nettype wire

// ===== tb/sv/tb.sv =====
// Self-checking bench for the prescaled multi-timer watchdog: tick, register read and
// register write items go in, and each result is checked against an in-bench timer model.
// Depends on pmtw_pkg, pmtw_ifs and the prescaled_multi_timer_watchdog top level.
`default_nettype none

module tb;
	import pmtw_pkg::*;

	localparam int NT          = 3;
	localparam int SC_W        = 16;
	localparam int CNT_W       = 32;
	localparam int CYCLE_LIMIT = 200000;
	localparam int DRAIN       = 10;

	// Offset of the latch registers, which read as zero
	localparam logic [1:0] REG_LATCH = 2'd3;
	// Command code with no meaning; the block must ignore it
	localparam logic [1:0] CMD_UNUSED = 2'd3;

	typedef struct packed {
		logic [DATA_W-1:0] rd;
		logic [IRQ_W-1:0]  irq;
		logic              wd;
	} unit_result_t;

	// Timer unit model plus the queue of results it still owes
	class timer_unit_scoreboard #(int NT = 3, int SC_W = 16, int CNT_W = 32);
		logic [SC_W-1:0]  scaler_cnt;
		logic [SC_W-1:0]  scaler_rld;
		logic [CNT_W-1:0] cnt[NT];
		logic [CNT_W-1:0] rld[NT];
		timer_stat_t      stat[NT];
		unit_result_t     expected_q[$];
		int               errors;
		int               checked;

		function new();
			scaler_cnt = '1;
			scaler_rld = '1;
			for (int t = 0; t < NT; t++) begin
				cnt[t]  = '0;
				rld[t]  = '0;
				stat[t] = '0;
			end
			errors  = 0;
			checked = 0;
		endfunction

		function void report(string msg);
			$display("mismatch: %s", msg);
			errors++;
		endfunction

		// Control register as the bus shows it; load never reads back
		function logic [DATA_W-1:0] ctrl_image(int t);
			logic [DATA_W-1:0] r;
			r = '0;
			r[CTRL_EN_BIT]    = stat[t].en;
			r[CTRL_PER_BIT]   = stat[t].per;
			r[CTRL_IE_BIT]    = stat[t].ie;
			r[CTRL_PEND_BIT]  = stat[t].pend;
			r[CTRL_CHAIN_BIT] = stat[t].chain;
			return r;
		endfunction

		// One system clock: prescaler, then the timer chain in order
		function void clock_tick();
			logic        prescale_hit;
			logic        carry;
			logic        advance;
			logic        wrapped;
			timer_stat_t s;
			int          t;
			prescale_hit = (scaler_cnt == '0);
			if (prescale_hit) begin
				scaler_cnt = scaler_rld;
			end else begin
				scaler_cnt = scaler_cnt - 1'b1;
			end
			carry = 1'b0;
			for (t = 0; t < NT; t++) begin
				s       = stat[t];
				advance = (t > 0 && s.chain) ? carry : prescale_hit;
				wrapped = 1'b0;
				if (s.en && advance) begin
					if (cnt[t] == '0) begin
						wrapped = 1'b1;
						if (s.per) begin
							cnt[t] = rld[t];
						end else begin
							cnt[t] = '1;
							s.en   = 1'b0;
						end
						if (s.ie) s.pend = 1'b1;
						stat[t] = s;
					end else begin
						cnt[t] = cnt[t] - 1'b1;
					end
				end
				carry = wrapped;
			end
		endfunction

		function logic [DATA_W-1:0] read_reg(logic [ADDR_W-1:0] addr);
			logic [2:0] grp;
			logic [1:0] off;
			int         t;
			grp = addr[4:2];
			off = addr[1:0];
			if (grp == GRP_GLOBAL) begin
				case (off)
					REG_SCALER:        return DATA_W'(scaler_cnt);
					REG_SCALER_RELOAD: return DATA_W'(scaler_rld);
					REG_CONFIG:        return DATA_W'(NT) & CONFIG_MASK;
					default:           return '0;
				endcase
			end
			if (int'(grp) > NT) return '0;
			t = int'(grp) - 1;
			case (off)
				REG_COUNT:  return DATA_W'(cnt[t]);
				REG_RELOAD: return DATA_W'(rld[t]);
				REG_CTRL:   return ctrl_image(t);
				default:    return '0;
			endcase
		endfunction

		function void write_reg(logic [ADDR_W-1:0] addr, logic [DATA_W-1:0] v);
			logic [2:0] grp;
			logic [1:0] off;
			int         t;
			grp = addr[4:2];
			off = addr[1:0];
			if (grp == GRP_GLOBAL) begin
				if (off == REG_SCALER) scaler_cnt = v[SC_W-1:0];
				else if (off == REG_SCALER_RELOAD) scaler_rld = v[SC_W-1:0];
				return;
			end
			if (int'(grp) > NT) return;
			t = int'(grp) - 1;
			case (off)
				REG_COUNT:  cnt[t] = v[CNT_W-1:0];
				REG_RELOAD: rld[t] = v[CNT_W-1:0];
				REG_CTRL: begin
					// writing pending as 1 clears it, as 0 keeps it
					stat[t].pend  = stat[t].pend & ~v[CTRL_PEND_BIT];
					stat[t].en    = v[CTRL_EN_BIT];
					stat[t].per   = v[CTRL_PER_BIT];
					stat[t].ie    = v[CTRL_IE_BIT];
					stat[t].chain = v[CTRL_CHAIN_BIT];
					if (v[CTRL_LOAD_BIT]) cnt[t] = rld[t];
				end
				default: ;
			endcase
		endfunction

		// Accepted item: advance the model and queue the result it owes
		function void note(cmd_e cmd, logic [ADDR_W-1:0] addr, logic [DATA_W-1:0] data);
			unit_result_t r;
			r = '0;
			case (cmd)
				CMD_TICK:  clock_tick();
				CMD_READ:  r.rd = read_reg(addr);
				CMD_WRITE: write_reg(addr, data);
				default: ;
			endcase
			for (int t = 0; t < NT; t++) r.irq[t] = stat[t].pend & stat[t].ie;
			r.wd = stat[NT-1].pend;
			expected_q.push_back(r);
		endfunction

		function void check(logic [DATA_W-1:0] rd, logic [IRQ_W-1:0] irq, logic wd);
			unit_result_t want;
			if (expected_q.size() == 0) begin
				report($sformatf("result with no item pending (read_data %h)", rd));
				return;
			end
			want = expected_q.pop_front();
			if (rd !== want.rd)
				report($sformatf("result %0d read_data %h, want %h", checked, rd, want.rd));
			if (irq !== want.irq)
				report($sformatf("result %0d irq_lines %b, want %b", checked, irq, want.irq));
			if (wd !== want.wd)
				report($sformatf("result %0d watchdog_fired %b, want %b", checked, wd, want.wd));
			checked++;
		endfunction

		function int pending();
			return expected_q.size();
		endfunction
	endclass

	logic clk;
	logic arst_n;
	int   send_idle_pct;
	int   recv_stall_pct;
	int   items_sent;

	pmtw_req_if req_ch();
	pmtw_rsp_if rsp_ch();

	timer_unit_scoreboard #(NT, SC_W, CNT_W) sb;

	prescaled_multi_timer_watchdog #(
		.NUM_TIMERS(NT),
		.SCALER_WIDTH(SC_W),
		.COUNTER_WIDTH(CNT_W)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.req(req_ch),
		.rsp(rsp_ch)
	);

	// Clock, period 12
	always begin
		clk = 1'b0;
		#6;
		clk = 1'b1;
		#6;
	end

	// Result side back-pressure
	always @(negedge clk) begin
		rsp_ch.ready <= ($urandom_range(0, 99) >= recv_stall_pct);
	end

	// Both handshakes seen at the rising edge
	always @(posedge clk) begin
		if (arst_n) begin
			if (req_ch.valid && req_ch.ready)
				sb.note(req_ch.command, req_ch.address, req_ch.write_data);
			if (rsp_ch.valid && rsp_ch.ready)
				sb.check(rsp_ch.read_data, rsp_ch.irq_lines, rsp_ch.watchdog_fired);
		end
	end

	// Run time limit
	initial begin
		repeat (CYCLE_LIMIT) @(posedge clk);
		$display("tb: FAIL");
		$finish;
	end

	function automatic logic [ADDR_W-1:0] reg_addr(int grp, logic [1:0] off);
		return {grp[2:0], off};
	endfunction

	function automatic logic [DATA_W-1:0] ctrl_word(bit en, bit per, bit load, bit ie,
			bit pend, bit chain);
		logic [DATA_W-1:0] v;
		v = '0;
		v[CTRL_EN_BIT]    = en;
		v[CTRL_PER_BIT]   = per;
		v[CTRL_LOAD_BIT]  = load;
		v[CTRL_IE_BIT]    = ie;
		v[CTRL_PEND_BIT]  = pend;
		v[CTRL_CHAIN_BIT] = chain;
		return v;
	endfunction

	// Called at a falling edge; returns at the falling edge after acceptance
	task automatic send_item(cmd_e cmd, logic [ADDR_W-1:0] addr, logic [DATA_W-1:0] data);
		while ($urandom_range(0, 99) < send_idle_pct) begin
			req_ch.valid <= 1'b0;
			@(negedge clk);
		end
		req_ch.valid      <= 1'b1;
		req_ch.command    <= cmd;
		req_ch.address    <= addr;
		req_ch.write_data <= data;
		@(posedge clk);
		while (!req_ch.ready) @(posedge clk);
		items_sent++;
		@(negedge clk);
	endtask

	// Small prescaler and reload values so that timers wrap often
	task automatic program_timers();
		logic [DATA_W-1:0] v;
		send_item(CMD_WRITE, reg_addr(0, REG_SCALER_RELOAD), DATA_W'($urandom_range(0, 3)));
		send_item(CMD_WRITE, reg_addr(0, REG_SCALER), DATA_W'($urandom_range(0, 3)));
		for (int t = 1; t <= NT; t++) begin
			if ($urandom_range(0, 2) != 0) begin
				v = ($urandom_range(0, 9) == 0) ? $urandom : DATA_W'($urandom_range(0, 6));
				send_item(CMD_WRITE, reg_addr(t, REG_RELOAD), v);
				if ($urandom_range(0, 3) == 0)
					send_item(CMD_WRITE, reg_addr(t, REG_COUNT), DATA_W'($urandom_range(0, 6)));
				v = $urandom;
				v[CTRL_EN_BIT] = ($urandom_range(0, 3) != 0);
				send_item(CMD_WRITE, reg_addr(t, REG_CTRL), v);
			end
		end
	endtask

	// Mostly ticks, with reads and pending clears mixed in
	task automatic run_burst(int n);
		int                pick;
		int                t;
		logic [DATA_W-1:0] v;
		repeat (n) begin
			pick = $urandom_range(0, 99);
			if (pick < 75) begin
				send_item(CMD_TICK, 5'($urandom_range(0, 31)), $urandom);
			end else if (pick < 90) begin
				send_item(CMD_READ, 5'($urandom_range(0, 31)), $urandom);
			end else begin
				t = $urandom_range(0, NT - 1);
				v = sb.ctrl_image(t);
				v[CTRL_PEND_BIT] = 1'b1;
				send_item(CMD_WRITE, reg_addr(t + 1, REG_CTRL), v);
			end
		end
	endtask

	task automatic noise_item();
		logic [1:0] c;
		c = ($urandom_range(0, 49) == 0) ? CMD_UNUSED : 2'($urandom_range(0, 2));
		send_item(cmd_e'(c), 5'($urandom_range(0, 31)), $urandom);
	endtask

	task automatic random_phase(int idle_pct, int stall_pct, int n);
		int target;
		int pick;
		send_idle_pct  = idle_pct;
		recv_stall_pct = stall_pct;
		target = items_sent + n;
		program_timers();
		while (items_sent < target) begin
			pick = $urandom_range(0, 99);
			if (pick < 12) program_timers();
			else if (pick < 22) noise_item();
			else run_burst($urandom_range(5, 30));
		end
	endtask

	task automatic directed_items();
		// reset values, config, latch and unused slots
		send_item(CMD_READ, reg_addr(0, REG_SCALER), '0);
		send_item(CMD_READ, reg_addr(0, REG_CONFIG), '0);
		send_item(CMD_READ, reg_addr(0, REG_LATCH), '1);
		send_item(CMD_READ, reg_addr(NT + 1, REG_COUNT), '0);
		send_item(CMD_WRITE, reg_addr(0, REG_CONFIG), '1);
		send_item(CMD_WRITE, reg_addr(1, REG_LATCH), '1);
		send_item(CMD_WRITE, reg_addr(NT + 1, REG_RELOAD), '1);
		send_item(CMD_READ, reg_addr(7, REG_LATCH), '0);
		// wide prescaler writes are masked
		send_item(CMD_WRITE, reg_addr(0, REG_SCALER_RELOAD), 32'hFFFF_0000);
		send_item(CMD_WRITE, reg_addr(0, REG_SCALER), '1);
		send_item(CMD_READ, reg_addr(0, REG_SCALER), '0);
		send_item(CMD_WRITE, reg_addr(0, REG_SCALER), '0);
		send_item(CMD_TICK, '0, '0);
		// timer 1 periodic with chain set (no effect on the first timer)
		send_item(CMD_WRITE, reg_addr(1, REG_RELOAD), 32'd1);
		send_item(CMD_WRITE, reg_addr(1, REG_CTRL), ctrl_word(1, 1, 1, 1, 0, 1));
		// timer 2 one-shot chained, timer 3 periodic chained
		send_item(CMD_WRITE, reg_addr(2, REG_CTRL), ctrl_word(1, 0, 1, 1, 0, 1));
		send_item(CMD_WRITE, reg_addr(3, REG_RELOAD), '1);
		send_item(CMD_WRITE, reg_addr(3, REG_CTRL), ctrl_word(1, 1, 0, 1, 0, 1));
		repeat (3) send_item(CMD_TICK, '1, '1);
		send_item(CMD_READ, reg_addr(2, REG_COUNT), '0);
		send_item(CMD_READ, reg_addr(2, REG_CTRL), '0);
		// pending kept by a zero write, cleared by a one
		send_item(CMD_WRITE, reg_addr(2, REG_CTRL), '0);
		send_item(CMD_WRITE, reg_addr(3, REG_CTRL), ctrl_word(0, 0, 0, 0, 1, 0));
		send_item(cmd_e'(CMD_UNUSED), reg_addr(0, REG_SCALER), '1);
		repeat (2) send_item(CMD_TICK, '0, '0);
	endtask

	initial begin
		sb             = new();
		items_sent     = 0;
		send_idle_pct  = 0;
		recv_stall_pct = 0;
		arst_n         = 1'b0;
		req_ch.valid      = 1'b0;
		req_ch.command    = CMD_TICK;
		req_ch.address    = '0;
		req_ch.write_data = '0;
		rsp_ch.ready      = 1'b0;
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		directed_items();
		random_phase(0, 0, 120);
		random_phase(61, 0, 120);
		random_phase(0, 61, 120);
		random_phase(34, 34, 120);
		random_phase(0, 0, 120);
		req_ch.valid <= 1'b0;

		while (sb.pending() != 0) @(posedge clk);
		repeat (DRAIN) @(posedge clk);
		if (sb.errors == 0) begin
			$display("tb: PASS");
		end else begin
			$display("tb: FAIL");
		end
		$finish;
	end

endmodule

`default_nettype wire
